@@ rtl/acs_pkg.sv @@
// shared types, codes and defaults for the affinity card scheduler
package acs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NUM_CARDS_DEF   = 8;
    localparam int USER_BITS_DEF   = 8;

    localparam logic [1:0] MODE_ENQUEUE   = 2'd0;
    localparam logic [1:0] MODE_SCHEDULE  = 2'd1;
    localparam logic [1:0] MODE_RESIDENCY = 2'd2;
    localparam logic [1:0] MODE_NOP       = 2'd3;

    localparam logic [2:0] STATUS_ENQUEUED = 3'd0;
    localparam logic [2:0] STATUS_DROPPED  = 3'd1;
    localparam logic [2:0] STATUS_GRANTED  = 3'd2;
    localparam logic [2:0] STATUS_NO_PLAN  = 3'd3;
    localparam logic [2:0] STATUS_RESIDENT = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] job_id;
        logic [7:0]  user_id;
        logic [3:0]  cards_needed;
        logic [7:0]  idle_mask;
        logic [2:0]  card_index;
        logic        resident_valid;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] granted_request;
        logic [7:0]  card_mask;
        logic [4:0]  queue_count;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WORK,
        ST_DONE
    } state_t;

endpackage

@@ rtl/acs_ram.sv @@
// generic single write port, single read port ram with registered read
module acs_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/acs_grant.sv @@
// card picker: one card per cycle, resident-user matches first, lowest index first
module acs_grant #(
    parameter int CARDS = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CARDS-1:0] pref,
    input  logic [CARDS-1:0] rest,
    input  logic [3:0]       need,
    output logic [CARDS-1:0] mask,
    output logic             done
);

    logic [3:0]       need_reg;
    logic [3:0]       need_next;
    logic [CARDS-1:0] pref_reg;
    logic [CARDS-1:0] pref_next;
    logic [CARDS-1:0] rest_reg;
    logic [CARDS-1:0] rest_next;
    logic [CARDS-1:0] mask_reg;
    logic [CARDS-1:0] mask_next;
    logic [CARDS-1:0] pool;
    logic [CARDS-1:0] pick;

    // lowest set bit of the preferred pool, else of the rest
    assign pool = (pref_reg != '0) ? pref_reg : rest_reg;
    assign pick = pool & (~pool + CARDS'(1));

    always_comb
    begin
        need_next = need_reg;
        pref_next = pref_reg;
        rest_next = rest_reg;
        mask_next = mask_reg;
        if (start)
        begin
            need_next = need;
            pref_next = pref;
            rest_next = rest;
            mask_next = '0;
        end
        else if (need_reg != 4'd0)
        begin
            need_next = need_reg - 4'd1;
            pref_next = pref_reg & ~pick;
            rest_next = rest_reg & ~pick;
            mask_next = mask_reg | pick;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_reg <= 4'd0;
        end
        else
        begin
            need_reg <= need_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pref_reg <= pref_next;
        rest_reg <= rest_next;
        mask_reg <= mask_next;
    end

    assign mask = mask_reg;
    assign done = (need_reg == 4'd0);

endmodule

@@ rtl/affinity_card_scheduler_core.sv @@
// Affinity-aware first-fit card scheduler. Enqueue, residency update and no-op beats go
// straight to the response stage after acceptance. A schedule beat scans the queue entries
// oldest first (one per cycle through the queue memory's read port); on a fit it moves the
// entries behind the granted one down (one per cycle), overlapped with the grant of the
// cards (one per cycle in the card picker); with no grant it ends after the scan, and it
// skips the scan when the queue or the idle mask is empty.
// The block takes no new beat until the current one has been handed to its response register,
// and is ready again the cycle after; a waiting response does not block acceptance of the
// next beat.
module affinity_card_scheduler_core #(
    parameter int QUEUE_DEPTH = acs_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_CARDS   = acs_pkg::NUM_CARDS_DEF,
    parameter int USER_BITS   = acs_pkg::USER_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  acs_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output acs_pkg::rsp_t rsp
);

    // only the cards the 8-bit idle mask can reach take part
    localparam int LIVE    = (NUM_CARDS < 8) ? NUM_CARDS : 8;
    localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = 16 + USER_BITS + 4;

    acs_pkg::state_t state_reg;
    acs_pkg::state_t state_next;

    logic [CNT_W-1:0]     pcount_reg;
    logic [CNT_W-1:0]     pcount_next;
    logic [CNT_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     idx_next;
    logic [LIVE-1:0]      idle_reg;
    logic [LIVE-1:0]      idle_next;
    logic [3:0]           nidle_reg;
    logic [3:0]           nidle_next;
    logic [3:0]           cards_reg;
    logic [3:0]           cards_next;
    logic [15:0]          gid_reg;
    logic [15:0]          gid_next;
    logic [2:0]           status_reg;
    logic [2:0]           status_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    acs_pkg::rsp_t        rsp_reg;
    acs_pkg::rsp_t        rsp_next;

    logic                 res_valid_reg [LIVE];
    logic                 res_valid_next [LIVE];
    logic [USER_BITS-1:0] res_user_reg [LIVE];
    logic [USER_BITS-1:0] res_user_next [LIVE];

    logic                 req_fire;
    logic [USER_BITS+7:0] user_ext;
    logic [USER_BITS-1:0] req_user;
    logic [LIVE-1:0]      req_idle;
    logic [3:0]           req_nidle;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic [3:0]           ent_cards;
    logic [USER_BITS-1:0] ent_user;
    logic [15:0]          ent_id;
    logic                 hit;
    logic                 scan_last;
    logic                 shift_done;
    logic [LIVE-1:0]      match;
    logic                 grant_start;
    logic [LIVE-1:0]      grant_mask;
    logic                 grant_done;

    assign req_ready = (state_reg == acs_pkg::ST_IDLE);
    assign req_fire  = req_valid && req_ready;

    assign user_ext = {USER_BITS'(0), req.user_id};
    assign req_user = user_ext[USER_BITS-1:0];
    assign req_idle = req.idle_mask[LIVE-1:0];

    always_comb
    begin
        req_nidle = 4'd0;
        for (int c = 0; c < LIVE; c++)
        begin
            req_nidle = req_nidle + {3'd0, req_idle[c]};
        end
    end

    assign ent_cards = ram_rdata[3:0];
    assign ent_user  = ram_rdata[USER_BITS+3:4];
    assign ent_id    = ram_rdata[ENTRY_W-1:USER_BITS+4];

    always_comb
    begin
        for (int c = 0; c < LIVE; c++)
        begin
            match[c] = res_valid_reg[c] && (res_user_reg[c] == ent_user);
        end
    end

    assign hit         = (ent_cards <= nidle_reg);
    assign scan_last   = ((idx_reg + CNT_W'(1)) == pcount_reg);
    assign shift_done  = (idx_reg >= pcount_reg);
    assign grant_start = (state_reg == acs_pkg::ST_SCAN) && hit;

    acs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_next[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    acs_grant #(
        .CARDS (LIVE)
    ) u_grant (
        .clk   (clk),
        .rst_n (rst_n),
        .start (grant_start),
        .pref  (idle_reg & match),
        .rest  (idle_reg & ~match),
        .need  (ent_cards),
        .mask  (grant_mask),
        .done  (grant_done)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            acs_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.mode == acs_pkg::MODE_SCHEDULE && pcount_reg != '0
                        && req_nidle != 4'd0)
                    begin
                        state_next = acs_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = acs_pkg::ST_DONE;
                    end
                end
            end
            acs_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = acs_pkg::ST_WORK;
                end
                else if (scan_last)
                begin
                    state_next = acs_pkg::ST_DONE;
                end
            end
            acs_pkg::ST_WORK:
            begin
                if (shift_done && grant_done)
                begin
                    state_next = acs_pkg::ST_DONE;
                end
            end
            acs_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = acs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = acs_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pcount_next    = pcount_reg;
        idx_next       = idx_reg;
        idle_next      = idle_reg;
        nidle_next     = nidle_reg;
        cards_next     = cards_reg;
        gid_next       = gid_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = pcount_reg[ADDR_W-1:0];
        ram_wdata      = {req.job_id, req_user, req.cards_needed};
        for (int c = 0; c < LIVE; c++)
        begin
            res_valid_next[c] = res_valid_reg[c];
            res_user_next[c]  = res_user_reg[c];
        end

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            acs_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (req.mode)
                        acs_pkg::MODE_ENQUEUE:
                        begin
                            if (pcount_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                status_next = acs_pkg::STATUS_DROPPED;
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                pcount_next = pcount_reg + CNT_W'(1);
                                status_next = acs_pkg::STATUS_ENQUEUED;
                            end
                        end
                        acs_pkg::MODE_SCHEDULE:
                        begin
                            idx_next    = '0;
                            idle_next   = req_idle;
                            nidle_next  = req_nidle;
                            status_next = acs_pkg::STATUS_NO_PLAN;
                        end
                        acs_pkg::MODE_RESIDENCY:
                        begin
                            for (int c = 0; c < LIVE; c++)
                            begin
                                if (req.card_index == 3'(c))
                                begin
                                    res_valid_next[c] = req.resident_valid;
                                    res_user_next[c]  = req_user;
                                end
                            end
                            status_next = acs_pkg::STATUS_RESIDENT;
                        end
                        acs_pkg::MODE_NOP:
                        begin
                            status_next = acs_pkg::STATUS_NO_PLAN;
                        end
                        default:
                        begin
                            status_next = acs_pkg::STATUS_NO_PLAN;
                        end
                    endcase
                end
            end
            acs_pkg::ST_SCAN:
            begin
                // one queue entry per cycle, oldest first
                idx_next = idx_reg + CNT_W'(1);
                if (hit)
                begin
                    gid_next    = ent_id;
                    cards_next  = ent_cards;
                    status_next = acs_pkg::STATUS_GRANTED;
                end
            end
            acs_pkg::ST_WORK:
            begin
                // close the gap: entry idx moves to idx-1 while the picker runs
                if (!shift_done)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(idx_reg - CNT_W'(1));
                    ram_wdata = ram_rdata;
                    idx_next  = idx_reg + CNT_W'(1);
                end
                else if (grant_done)
                begin
                    pcount_next = pcount_reg - CNT_W'(1);
                end
            end
            acs_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_next.status          = status_reg;
                    rsp_next.granted_request =
                        (status_reg == acs_pkg::STATUS_GRANTED) ? gid_reg : 16'd0;
                    rsp_next.card_mask       =
                        (status_reg == acs_pkg::STATUS_GRANTED) ? 8'(grant_mask) : 8'd0;
                    rsp_next.queue_count     = 5'(pcount_reg);
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= acs_pkg::ST_IDLE;
            pcount_reg    <= '0;
            rsp_valid_reg <= 1'b0;
            for (int c = 0; c < LIVE; c++)
            begin
                res_valid_reg[c] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pcount_reg    <= pcount_next;
            rsp_valid_reg <= rsp_valid_next;
            for (int c = 0; c < LIVE; c++)
            begin
                res_valid_reg[c] <= res_valid_next[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        idle_reg   <= idle_next;
        nidle_reg  <= nidle_next;
        cards_reg  <= cards_next;
        gid_reg    <= gid_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
        for (int c = 0; c < LIVE; c++)
        begin
            res_user_reg[c] <= res_user_next[c];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // queue never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        pcount_reg <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

    // a scan only starts on a non-empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == acs_pkg::ST_SCAN |-> pcount_reg != '0)
    else $error("scan of empty queue");

    // granted cards are idle and exactly as many as the request needs
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == acs_pkg::ST_WORK && grant_done)
        |-> ((grant_mask & ~idle_reg) == '0
             && $countones(grant_mask) == int'(cards_reg)))
    else $error("grant mask wrong");

    // a grant removes exactly one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == acs_pkg::ST_WORK && shift_done && grant_done)
        |=> pcount_reg == $past(pcount_reg) - CNT_W'(1))
    else $error("grant did not remove one entry");

endmodule
